FILE: hw/rtl/cwe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the binomial row builder for the
// constant-weight codeword encoder. No dependencies.
package cwe_pkg;

  localparam int CW_IDX_W = 64;
  localparam int CW_MAX   = 64;
  localparam int CW_CFG_W = 7;

  typedef enum logic [0:0] {
    REG_CODE_LENGTH = 1'b0,
    REG_CODE_WEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [CW_IDX_W-1:0] binom_row_t [0:CW_MAX];

  typedef struct packed {
    logic                valid;
    logic                bad;
    logic                wrap;
    logic [CW_CFG_W-1:0] len;
    logic [CW_CFG_W-1:0] wt;
  } cwe_ctl_t;

  // Row n of Pascal's triangle, built at elaboration.
  function automatic binom_row_t binom_row(input int n);
    binom_row_t cur;
    binom_row_t prv;
    for (int k = 0; k <= CW_MAX; k++) begin
      cur[k] = (k == 0) ? 64'd1 : 64'd0;
    end
    for (int r = 1; r <= n; r++) begin
      prv = cur;
      for (int k = 1; k <= CW_MAX; k++) begin
        cur[k] = prv[k-1] + prv[k];
      end
    end
    return cur;
  endfunction

endpackage

FILE: hw/rtl/cwe_count.sv
`timescale 1ns / 1ps
// Two-stage lookup of the codeword count C(length, weight).
// Depends on cwe_pkg.
module cwe_count
  import cwe_pkg::*;
#(
  parameter int MAX_LENGTH = CW_MAX
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cwe_ctl_t            ctl_in,
  input  logic [CW_IDX_W-1:0] idx_in,
  output cwe_ctl_t            ctl_out,
  output logic [CW_IDX_W-1:0] idx_out,
  output logic [CW_IDX_W-1:0] count_out
);
  localparam int LW = $clog2(MAX_LENGTH + 1);

  cwe_ctl_t            ctl1_r, ctl2_r;
  logic [CW_IDX_W-1:0] idx1_r, idx2_r, count_r;
  logic [CW_IDX_W-1:0] val_r [0:MAX_LENGTH];

  // Stage 1: column by weight, one entry per row.
  for (genvar n = 0; n <= MAX_LENGTH; n++) begin : g_row
    localparam binom_row_t ROW = binom_row(n);
    always_ff @(posedge clk) begin
      if (en) val_r[n] <= ROW[ctl_in.wt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      ctl2_r.valid <= 1'b0;
    end else if (en) begin
      ctl1_r  <= ctl_in;
      idx1_r  <= idx_in;
      ctl2_r  <= ctl1_r;
      idx2_r  <= idx1_r;
      // Stage 2: pick the row by length.
      count_r <= val_r[ctl1_r.len[LW-1:0]];
    end
  end

  assign ctl_out   = ctl2_r;
  assign idx_out   = idx2_r;
  assign count_out = count_r;
endmodule

FILE: hw/rtl/cwe_mod.sv
`timescale 1ns / 1ps
// Pipelined restoring remainder: one index bit per stage.
// Depends on cwe_pkg.
module cwe_mod
  import cwe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cwe_ctl_t            ctl_in,
  input  logic [CW_IDX_W-1:0] idx_in,
  input  logic [CW_IDX_W-1:0] count_in,
  output cwe_ctl_t            ctl_out,
  output logic [CW_IDX_W-1:0] rem_out
);
  cwe_ctl_t            ctl_r [0:CW_IDX_W-1];
  logic [CW_IDX_W-1:0] rem_r [0:CW_IDX_W-1];
  logic [CW_IDX_W-1:0] idx_r [0:CW_IDX_W-1];
  logic [CW_IDX_W-1:0] cnt_r [0:CW_IDX_W-1];

  for (genvar i = 0; i < CW_IDX_W; i++) begin : g_stg
    cwe_ctl_t            ctl_p, ctl_nxt;
    logic [CW_IDX_W-1:0] rem_p, idx_p, cnt_p, rem_nxt;
    logic [CW_IDX_W:0]   sh;

    if (i == 0) begin : g_first
      always_comb begin
        ctl_p      = ctl_in;
        ctl_p.wrap = (idx_in >= count_in);
        rem_p      = '0;
        idx_p      = idx_in;
        cnt_p      = count_in;
      end
    end else begin : g_next
      assign ctl_p = ctl_r[i-1];
      assign rem_p = rem_r[i-1];
      assign idx_p = idx_r[i-1];
      assign cnt_p = cnt_r[i-1];
    end

    always_comb begin
      ctl_nxt = ctl_p;
      sh      = {rem_p, idx_p[CW_IDX_W-1]};
      if (sh >= {1'b0, cnt_p}) sh = sh - {1'b0, cnt_p};
      rem_nxt = sh[CW_IDX_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i].valid <= 1'b0;
      end else if (en) begin
        ctl_r[i] <= ctl_nxt;
        rem_r[i] <= rem_nxt;
        idx_r[i] <= {idx_p[CW_IDX_W-2:0], 1'b0};
        cnt_r[i] <= cnt_p;
      end
    end
  end

  assign ctl_out = ctl_r[CW_IDX_W-1];
  assign rem_out = rem_r[CW_IDX_W-1];
endmodule

FILE: hw/rtl/cwe_unrank.sv
`timescale 1ns / 1ps
// One stage per codeword position, top position first.
// Depends on cwe_pkg.
module cwe_unrank
  import cwe_pkg::*;
#(
  parameter int MAX_LENGTH = CW_MAX
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cwe_ctl_t            ctl_in,
  input  logic [CW_IDX_W-1:0] rem_in,
  output cwe_ctl_t            ctl_out,
  output logic [CW_IDX_W-1:0] word_out
);
  cwe_ctl_t            ctl_r  [0:MAX_LENGTH-1];
  logic [CW_IDX_W-1:0] rem_r  [0:MAX_LENGTH-1];
  logic [CW_IDX_W-1:0] word_r [0:MAX_LENGTH-1];

  for (genvar j = 0; j < MAX_LENGTH; j++) begin : g_pos
    localparam int POS = MAX_LENGTH - 1 - j;
    localparam binom_row_t ROW = binom_row(POS);
    cwe_ctl_t            ctl_p, ctl_nxt;
    logic [CW_IDX_W-1:0] rem_p, word_p, rem_nxt, word_nxt;
    logic [CW_IDX_W-1:0] b;

    if (j == 0) begin : g_first
      assign ctl_p  = ctl_in;
      assign rem_p  = rem_in;
      assign word_p = '0;
    end else begin : g_next
      assign ctl_p  = ctl_r[j-1];
      assign rem_p  = rem_r[j-1];
      assign word_p = word_r[j-1];
    end

    assign b = ROW[ctl_p.wt];

    always_comb begin
      ctl_nxt  = ctl_p;
      rem_nxt  = rem_p;
      word_nxt = word_p;
      if (CW_CFG_W'(POS) < ctl_p.len && ctl_p.wt != '0 && rem_p >= b) begin
        word_nxt[POS] = 1'b1;
        rem_nxt       = rem_p - b;
        ctl_nxt.wt    = ctl_p.wt - 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j].valid <= 1'b0;
      end else if (en) begin
        ctl_r[j]  <= ctl_nxt;
        rem_r[j]  <= rem_nxt;
        word_r[j] <= word_nxt;
      end
    end
  end

  assign ctl_out  = ctl_r[MAX_LENGTH-1];
  assign word_out = word_r[MAX_LENGTH-1];
endmodule

FILE: hw/rtl/constant_weight_codeword_encoder.sv
`timescale 1ns / 1ps
// Constant-weight codeword encoder: count lookup, remainder pipeline, unranking.
// Throughput: one request per cycle; a stalled result holds the whole pipeline.
// Reset: code_length returns to 16, code_weight to 2, all stages empty.
// Depends on cwe_pkg, cwe_count, cwe_mod, cwe_unrank.
module constant_weight_codeword_encoder
  import cwe_pkg::*;
#(
  parameter int MAX_LENGTH = CW_MAX
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CW_CFG_W-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CW_IDX_W-1:0] in_index_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CW_IDX_W-1:0] out_codeword,
  output logic                out_wrapped,
  output logic                out_bad_setting
);
  logic [CW_CFG_W-1:0] len_r, wt_r, len_eff;
  logic                en, bad;
  cwe_ctl_t            ctl0, ctl_c, ctl_m, ctl_u;
  logic [CW_IDX_W-1:0] idx_c, cnt_c, rem_m, word_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= CW_CFG_W'(16);
      wt_r  <= CW_CFG_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CODE_LENGTH: len_r <= cfg_wdata;
        REG_CODE_WEIGHT: wt_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate length at the largest supported codeword.
  assign len_eff = (len_r > CW_CFG_W'(MAX_LENGTH)) ? CW_CFG_W'(MAX_LENGTH) : len_r;
  assign bad     = (wt_r > len_eff);

  // Advance everything unless a finished result is held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    ctl0.valid = in_valid;
    ctl0.bad   = bad;
    ctl0.wrap  = 1'b0;
    ctl0.len   = len_eff;
    ctl0.wt    = bad ? '0 : wt_r;
  end

  cwe_count #(.MAX_LENGTH(MAX_LENGTH)) u_count (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_in(ctl0), .idx_in(in_index_value),
    .ctl_out(ctl_c), .idx_out(idx_c), .count_out(cnt_c)
  );

  cwe_mod u_mod (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_in(ctl_c), .idx_in(idx_c),
    .count_in(cnt_c), .ctl_out(ctl_m), .rem_out(rem_m)
  );

  cwe_unrank #(.MAX_LENGTH(MAX_LENGTH)) u_unrank (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_in(ctl_m), .rem_in(rem_m),
    .ctl_out(ctl_u), .word_out(word_u)
  );

  assign out_valid       = ctl_u.valid;
  assign out_codeword    = ctl_u.bad ? '0 : word_u;
  assign out_wrapped     = ctl_u.wrap && !ctl_u.bad;
  assign out_bad_setting = ctl_u.bad;

  // Every weight is placed by the end of the position stages.
  a_all_placed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ctl_u.wt == '0)
    else $error("ones left unplaced");

  a_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_codeword))
    else $error("result changed under stall");

  a_high_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_codeword >> ctl_u.len) == '0)
    else $error("codeword bit set above length");

  a_stall_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("stall decode mismatch");
endmodule
